@@ rtl/pinned_lru_entry_cache_defines.svh @@
// Assertion macros used by the checker of the entry cache.
// No dependencies; include this file by its bare name.
`ifndef PINNED_LRU_ENTRY_CACHE_DEFINES_SVH
`define PINNED_LRU_ENTRY_CACHE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define PLC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/plc_pkg.sv @@
// Shared types and constants of the pinned entry cache.
// Used by plc_cell, pinned_lru_entry_cache and plc_checker; no dependencies.
`default_nettype none

package plc_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_BITS  = 32;
    localparam int REF_BITS  = 8;
    localparam int STAMP_W   = 48;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LIMIT_W   = 5;
    localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int SCNT_W    = $clog2(CAPACITY + 2);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    // Request codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_UNPIN  = 2'd2;

    // Answer status codes.
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_MISS     = 3'd2;
    localparam logic [2:0] ST_MISS_RET = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_UNKNOWN  = 3'd5;
    localparam logic [2:0] ST_NOT_PIN  = 3'd6;
    localparam logic [2:0] ST_OVERFLOW = 3'd7;

    // Commands from the sequencer to one cell.
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_NEW    = 3'd1;
    localparam logic [2:0] CMD_PIN    = 3'd2;
    localparam logic [2:0] CMD_UNPIN  = 3'd3;
    localparam logic [2:0] CMD_RETIRE = 3'd4;

    typedef struct packed {
        logic [2:0]          op;
        logic [SLOT_W-1:0]   idx;
        logic [KEY_BITS-1:0] key;
        logic                gapless;
        logic [STAMP_W-1:0]  stamp;
    } t_cmd;

    // Search record that travels down the row of cells.
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   hit_idx;
        logic [REF_BITS-1:0] hit_refs;
        logic                hit_gl;
        logic                free;
        logic [SLOT_W-1:0]   free_idx;
        logic                idle;
        logic [SLOT_W-1:0]   idle_idx;
        logic [STAMP_W-1:0]  idle_stamp;
        logic [KEY_BITS-1:0] idle_key;
        logic                idle_gl;
    } t_scan;

endpackage

`default_nettype wire

@@ rtl/plc_cell.sv @@
// One table slot: holds an entry and folds it into the passing search record.
// Depends on plc_pkg.
`default_nettype none

module plc_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [plc_pkg::SLOT_W-1:0]    i_idx,
    input  wire logic [plc_pkg::KEY_BITS-1:0]  i_req_key,
    input  wire plc_pkg::t_cmd                 i_cmd,
    input  wire plc_pkg::t_scan                i_scan,
    output plc_pkg::t_scan                     o_scan
);

    logic                         r_valid;
    logic [plc_pkg::REF_BITS-1:0] r_refs;
    logic [plc_pkg::KEY_BITS-1:0] r_key;
    logic [plc_pkg::STAMP_W-1:0]  r_stamp;
    logic                         r_gl;
    plc_pkg::t_scan               r_scan;
    plc_pkg::t_scan               n_scan;
    logic                         sel;

    assign sel = (i_cmd.idx == i_idx);

    // Entry state, cleared by reset and otherwise changed only by a command addressed to this slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_refs  <= '0;
        end else if (sel) begin
            case (i_cmd.op)
                plc_pkg::CMD_NEW: begin
                    r_valid <= 1'b1;
                    r_refs  <= plc_pkg::REF_BITS'(1);
                end
                plc_pkg::CMD_PIN:    r_refs <= r_refs + 1'b1;
                plc_pkg::CMD_UNPIN:  r_refs <= r_refs - 1'b1;
                plc_pkg::CMD_RETIRE: begin
                    r_valid <= 1'b0;
                    r_refs  <= '0;
                end
                default: ;
            endcase
        end
    end

    // Payload of the entry.
    always_ff @(posedge i_clk) begin
        if (sel && i_cmd.op == plc_pkg::CMD_NEW) begin
            r_key <= i_cmd.key;
            r_gl  <= i_cmd.gapless;
        end
        if (sel && (i_cmd.op == plc_pkg::CMD_NEW || i_cmd.op == plc_pkg::CMD_PIN)) begin
            r_stamp <= i_cmd.stamp;
        end
    end

    // Fold this slot into the record: first match, first free, oldest idle.
    always_comb begin
        n_scan = i_scan;
        if (!i_scan.hit && r_valid && r_key == i_req_key) begin
            n_scan.hit      = 1'b1;
            n_scan.hit_idx  = i_idx;
            n_scan.hit_refs = r_refs;
            n_scan.hit_gl   = r_gl;
        end
        if (!i_scan.free && !r_valid) begin
            n_scan.free     = 1'b1;
            n_scan.free_idx = i_idx;
        end
        if (r_valid && r_refs == '0 && (!i_scan.idle || r_stamp < i_scan.idle_stamp)) begin
            n_scan.idle       = 1'b1;
            n_scan.idle_idx   = i_idx;
            n_scan.idle_stamp = r_stamp;
            n_scan.idle_key   = r_key;
            n_scan.idle_gl    = r_gl;
        end
    end

    // Hand the record to the next slot.
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

@@ rtl/pinned_lru_entry_cache.sv @@
// Top level of the pinned entry cache: request sequencer and the row of cells.
// Depends on plc_pkg and plc_cell.
//
// Usage: a request word (op, key, gapless, want_gapless) enters on the
// i_valid / o_ready channel; o_ready is high only while no request is in
// work. Each request gives zero or more retire reports (o_kind 1) followed
// by one answer word (o_kind 0, o_last 1) on the o_valid / i_ready channel.
// A request with the unused op code gives no word at all.
// The search runs down a row of CAPACITY cells, one cell per cycle. A find
// or unpin ends with its decision, plus an answer step when it retires its
// entry; an insert that pins or places its entry adds a check and an answer
// step. Each entry an insert retires adds one search, one check and one
// decision; when the table is still over the limit with nothing idle, one
// last search and the answer follow. The result is held in one output
// register; a stalled receiver holds it there and the sequencer waits
// before it loads the next word. The soft limit is written on i_cfg_valid /
// o_cfg_ready, always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. Synchronous reset clears
// every slot, the access counter and the entry count and sets the soft limit to 3.
`default_nettype none

module pinned_lru_entry_cache (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_op,
    input  wire logic [plc_pkg::KEY_BITS-1:0]  i_key,
    input  wire logic                          i_gapless,
    input  wire logic                          i_want_gapless,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_kind,
    output logic [2:0]                         o_status,
    output logic [plc_pkg::KEY_BITS-1:0]       o_key_out,
    output logic [plc_pkg::SLOT_W-1:0]         o_slot,
    output logic                               o_entry_gapless,
    output logic                               o_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [plc_pkg::LIMIT_W-1:0]   i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_CDEC  = 3'd4;
    localparam logic [2:0] S_ANS   = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic                          r_clean, n_clean;
    logic [plc_pkg::SCNT_W-1:0]    r_scnt, n_scnt;
    logic [plc_pkg::LIMIT_W-1:0]   r_limit;
    logic [plc_pkg::CNT_W-1:0]     r_count, n_count;
    logic [plc_pkg::STAMP_W-1:0]   r_ctr, n_ctr;
    logic [1:0]                    r_op;
    logic [plc_pkg::KEY_BITS-1:0]  r_key;
    logic                          r_gl_in;
    logic                          r_prefer;
    logic [2:0]                    r_ans_status, n_ans_status;
    logic [plc_pkg::SLOT_W-1:0]    r_ans_slot, n_ans_slot;
    logic                          r_ans_gl, n_ans_gl;

    logic                          r_o_valid;
    logic                          r_o_kind;
    logic [2:0]                    r_o_status;
    logic [plc_pkg::KEY_BITS-1:0]  r_o_key;
    logic [plc_pkg::SLOT_W-1:0]    r_o_slot;
    logic                          r_o_gl;
    logic                          r_o_last;

    logic                          emit;
    logic                          e_kind;
    logic [2:0]                    e_status;
    logic [plc_pkg::KEY_BITS-1:0]  e_key;
    logic [plc_pkg::SLOT_W-1:0]    e_slot;
    logic                          e_gl;
    logic                          e_last;

    plc_pkg::t_cmd                 cmd;
    plc_pkg::t_scan                scan_chain [plc_pkg::CAPACITY];
    plc_pkg::t_scan                sc;
    logic                          out_free;
    logic                          over;
    logic                          accept;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_o_valid || i_ready;
    assign over        = plc_pkg::CMP_W'(r_count) > plc_pkg::CMP_W'(r_limit);
    assign sc          = scan_chain[plc_pkg::CAPACITY-1];

    // Row of cells; each hands its search record to the next.
    for (genvar g = 0; g < plc_pkg::CAPACITY; g++) begin : g_cell
        plc_pkg::t_scan scan_in;
        if (g == 0) begin : g_head
            assign scan_in = '0;
        end else begin : g_body
            assign scan_in = scan_chain[g-1];
        end
        plc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (plc_pkg::SLOT_W'(g)),
            .i_req_key (r_key),
            .i_cmd     (cmd),
            .i_scan    (scan_in),
            .o_scan    (scan_chain[g])
        );
    end

    // Request sequencer.
    always_comb begin
        n_state      = r_state;
        n_clean      = r_clean;
        n_scnt       = r_scnt;
        n_count      = r_count;
        n_ctr        = r_ctr;
        n_ans_status = r_ans_status;
        n_ans_slot   = r_ans_slot;
        n_ans_gl     = r_ans_gl;
        cmd          = '0;
        cmd.op       = plc_pkg::CMD_NONE;
        cmd.key      = r_key;
        cmd.gapless  = r_gl_in;
        cmd.stamp    = r_ctr + 1'b1;
        emit         = 1'b0;
        e_kind       = 1'b0;
        e_status     = plc_pkg::ST_HIT;
        e_key        = r_key;
        e_slot       = '0;
        e_gl         = 1'b0;
        e_last       = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_clean = 1'b0;
                    n_scnt  = '0;
                end
            end
            S_SCAN: begin
                n_scnt = r_scnt + 1'b1;
                if (r_scnt == plc_pkg::SCNT_W'(plc_pkg::CAPACITY)) begin
                    n_state = r_clean ? S_CDEC : S_DEC;
                end
            end
            S_DEC: begin
                if (out_free) begin
                    case (r_op)
                        plc_pkg::OP_INSERT: begin
                            if (sc.hit && sc.hit_refs == plc_pkg::REF_MAX) begin
                                emit     = 1'b1;
                                e_status = plc_pkg::ST_OVERFLOW;
                                e_slot   = sc.hit_idx;
                                e_gl     = sc.hit_gl;
                                n_state  = S_IDLE;
                            end else if (sc.hit) begin
                                cmd.op       = plc_pkg::CMD_PIN;
                                cmd.idx      = sc.hit_idx;
                                n_ctr        = r_ctr + 1'b1;
                                n_ans_status = plc_pkg::ST_HIT;
                                n_ans_slot   = sc.hit_idx;
                                n_ans_gl     = sc.hit_gl;
                                n_state      = S_CHECK;
                            end else if (!sc.free) begin
                                emit     = 1'b1;
                                e_status = plc_pkg::ST_FULL;
                                n_state  = S_IDLE;
                            end else begin
                                cmd.op       = plc_pkg::CMD_NEW;
                                cmd.idx      = sc.free_idx;
                                n_ctr        = r_ctr + 1'b1;
                                n_count      = r_count + 1'b1;
                                n_ans_status = plc_pkg::ST_NEW;
                                n_ans_slot   = sc.free_idx;
                                n_ans_gl     = r_gl_in;
                                n_state      = S_CHECK;
                            end
                        end
                        plc_pkg::OP_FIND: begin
                            n_state = S_IDLE;
                            emit    = 1'b1;
                            e_slot  = sc.hit_idx;
                            e_gl    = sc.hit_gl;
                            if (!sc.hit) begin
                                e_status = plc_pkg::ST_MISS;
                                e_slot   = '0;
                                e_gl     = 1'b0;
                            end else if (r_prefer && sc.hit_refs == '0 && !sc.hit_gl) begin
                                // Idle entry that is not gapless: retire it, then miss.
                                e_kind       = 1'b1;
                                e_last       = 1'b0;
                                cmd.op       = plc_pkg::CMD_RETIRE;
                                cmd.idx      = sc.hit_idx;
                                n_count      = r_count - 1'b1;
                                n_ans_status = plc_pkg::ST_MISS_RET;
                                n_ans_slot   = sc.hit_idx;
                                n_ans_gl     = 1'b0;
                                n_state      = S_ANS;
                            end else if (sc.hit_refs == plc_pkg::REF_MAX) begin
                                e_status = plc_pkg::ST_OVERFLOW;
                            end else begin
                                cmd.op   = plc_pkg::CMD_PIN;
                                cmd.idx  = sc.hit_idx;
                                n_ctr    = r_ctr + 1'b1;
                                e_status = plc_pkg::ST_HIT;
                            end
                        end
                        plc_pkg::OP_UNPIN: begin
                            n_state = S_IDLE;
                            emit    = 1'b1;
                            e_slot  = sc.hit_idx;
                            e_gl    = sc.hit_gl;
                            if (!sc.hit) begin
                                e_status = plc_pkg::ST_UNKNOWN;
                                e_slot   = '0;
                                e_gl     = 1'b0;
                            end else if (sc.hit_refs == '0) begin
                                e_status = plc_pkg::ST_NOT_PIN;
                            end else begin
                                cmd.op   = plc_pkg::CMD_UNPIN;
                                cmd.idx  = sc.hit_idx;
                                e_status = plc_pkg::ST_HIT;
                                if (sc.hit_refs == plc_pkg::REF_BITS'(1) && over) begin
                                    // Last pin released while over the limit.
                                    e_kind       = 1'b1;
                                    e_last       = 1'b0;
                                    cmd.op       = plc_pkg::CMD_RETIRE;
                                    n_count      = r_count - 1'b1;
                                    n_ans_status = plc_pkg::ST_HIT;
                                    n_ans_slot   = sc.hit_idx;
                                    n_ans_gl     = sc.hit_gl;
                                    n_state      = S_ANS;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (over) begin
                    n_state = S_SCAN;
                    n_clean = 1'b1;
                    n_scnt  = '0;
                end else begin
                    n_state = S_ANS;
                end
            end
            S_CDEC: begin
                if (!sc.idle) begin
                    n_state = S_ANS;
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = 1'b1;
                    e_last  = 1'b0;
                    e_key   = sc.idle_key;
                    e_slot  = sc.idle_idx;
                    e_gl    = sc.idle_gl;
                    cmd.op  = plc_pkg::CMD_RETIRE;
                    cmd.idx = sc.idle_idx;
                    n_count = r_count - 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_ANS: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = r_ans_status;
                    e_slot   = r_ans_slot;
                    e_gl     = r_ans_gl;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clean   <= 1'b0;
            r_scnt    <= '0;
            r_count   <= '0;
            r_ctr     <= '0;
            r_limit   <= plc_pkg::LIMIT_W'(3);
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clean <= n_clean;
            r_scnt  <= n_scnt;
            r_count <= n_count;
            r_ctr   <= n_ctr;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request and answer payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_op;
            r_key    <= i_key;
            r_gl_in  <= i_gapless;
            r_prefer <= i_want_gapless;
        end
        r_ans_status <= n_ans_status;
        r_ans_slot   <= n_ans_slot;
        r_ans_gl     <= n_ans_gl;
        if (emit) begin
            r_o_kind   <= e_kind;
            r_o_status <= e_status;
            r_o_key    <= e_key;
            r_o_slot   <= e_slot;
            r_o_gl     <= e_gl;
            r_o_last   <= e_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_status        = r_o_status;
    assign o_key_out       = r_o_key;
    assign o_slot          = r_o_slot;
    assign o_entry_gapless = r_o_gl;
    assign o_last          = r_o_last;

endmodule

`default_nettype wire

@@ rtl/plc_checker.sv @@
// Port-level checks of the entry cache, bound to the top level.
// Depends on plc_pkg and pinned_lru_entry_cache_defines.svh.
`default_nettype none
`include "pinned_lru_entry_cache_defines.svh"

module plc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic                          o_kind,
    input wire logic [2:0]                    o_status,
    input wire logic [plc_pkg::KEY_BITS-1:0]  o_key_out,
    input wire logic                          o_last
);

    // A stalled word holds its key.
    `PLC_ASSERT(a_hold, o_valid && !i_ready |=> o_valid && $stable(o_key_out), "word dropped")
    // Reports never close a request; answers always do.
    `PLC_ASSERT(a_last, o_valid |-> (o_kind != o_last), "kind and last disagree")
    // A retire report carries status zero.
    `PLC_ASSERT(a_rep, o_valid && o_kind |-> o_status == plc_pkg::ST_HIT, "bad report status")
    // Reset leaves no word pending.
    `PLC_ASSERT_ALWAYS(a_rst, !i_rst_n |=> !o_valid, "word after reset")

endmodule

bind pinned_lru_entry_cache plc_checker u_plc_checker (.*);

`default_nettype wire
